>>> src/rxrb_pkg.sv
// Package for the receive ring buffer with realtime command filter.
// Holds operation, event and register index codes, reset values and shared types.
// No dependencies.
package rxrb_pkg;

    localparam int BUFFER_DEPTH_DEF = 128;

    localparam int NUM_CODES = 5;
    localparam int IDX_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int FILL_W    = 7;
    localparam int EVT_W     = 3;

    localparam logic [1:0] OP_RX    = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    localparam logic [IDX_W-1:0] REG_STATUS = 3'd0;
    localparam logic [IDX_W-1:0] REG_CYCLE  = 3'd1;
    localparam logic [IDX_W-1:0] REG_HOLD   = 3'd2;
    localparam logic [IDX_W-1:0] REG_DOOR   = 3'd3;
    localparam logic [IDX_W-1:0] REG_RESET  = 3'd4;

    localparam logic [EVT_W-1:0] EVT_NONE   = 3'd0;
    localparam logic [EVT_W-1:0] EVT_STATUS = 3'd1;
    localparam logic [EVT_W-1:0] EVT_CYCLE  = 3'd2;
    localparam logic [EVT_W-1:0] EVT_HOLD   = 3'd3;
    localparam logic [EVT_W-1:0] EVT_DOOR   = 3'd4;
    localparam logic [EVT_W-1:0] EVT_RESET  = 3'd5;

    localparam logic [BYTE_W-1:0] CODE_STATUS_RST = 8'd63;
    localparam logic [BYTE_W-1:0] CODE_CYCLE_RST  = 8'd126;
    localparam logic [BYTE_W-1:0] CODE_HOLD_RST   = 8'd33;
    localparam logic [BYTE_W-1:0] CODE_DOOR_RST   = 8'd64;
    localparam logic [BYTE_W-1:0] CODE_RESET_RST  = 8'd24;

    localparam logic [BYTE_W-1:0] EMPTY_DATA = 8'hFF;

    typedef struct packed {
        logic              hit;
        logic [EVT_W-1:0]  evt;
        logic              ovf;
        logic [FILL_W-1:0] fill;
    } rxrb_status_t;

endpackage

>>> src/rxrb_cmd_if.sv
// Command channel: operation and received line byte.
// Depends on rxrb_pkg.
interface rxrb_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 operation;
    logic [rxrb_pkg::BYTE_W-1:0] line_byte;

    modport source (output valid, output operation, output line_byte, input ready);
    modport sink   (input valid, input operation, input line_byte, output ready);
endinterface

>>> src/rxrb_rsp_if.sv
// Response channel: popped data, fill count, event and overflow flag.
// Depends on rxrb_pkg.
interface rxrb_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [rxrb_pkg::BYTE_W-1:0] read_data;
    logic                        read_valid;
    logic [rxrb_pkg::FILL_W-1:0] fill_count;
    logic [rxrb_pkg::EVT_W-1:0]  realtime_event;
    logic                        overflow;

    modport source (output valid, output read_data, output read_valid, output fill_count,
                    output realtime_event, output overflow, input ready);
    modport sink   (input valid, input read_data, input read_valid, input fill_count,
                    input realtime_event, input overflow, output ready);
endinterface

>>> src/rxrb_ram.sv
// Byte store: one write port, one read port with registered read data.
// Depends on nothing.
module rxrb_ram #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/rxrb_filter.sv
// Command code registers and priority match of a received byte.
// Depends on rxrb_pkg.
module rxrb_filter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [rxrb_pkg::IDX_W-1:0]   wr_index,
    input  logic [rxrb_pkg::BYTE_W-1:0]  wr_data,
    input  logic [rxrb_pkg::BYTE_W-1:0]  line_byte,
    output logic [rxrb_pkg::EVT_W-1:0]   evt
);

    logic [rxrb_pkg::BYTE_W-1:0] status_reg;
    logic [rxrb_pkg::BYTE_W-1:0] cycle_reg;
    logic [rxrb_pkg::BYTE_W-1:0] hold_reg;
    logic [rxrb_pkg::BYTE_W-1:0] door_reg;
    logic [rxrb_pkg::BYTE_W-1:0] reset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= rxrb_pkg::CODE_STATUS_RST;
            cycle_reg  <= rxrb_pkg::CODE_CYCLE_RST;
            hold_reg   <= rxrb_pkg::CODE_HOLD_RST;
            door_reg   <= rxrb_pkg::CODE_DOOR_RST;
            reset_reg  <= rxrb_pkg::CODE_RESET_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                rxrb_pkg::REG_STATUS: status_reg <= wr_data;
                rxrb_pkg::REG_CYCLE:  cycle_reg  <= wr_data;
                rxrb_pkg::REG_HOLD:   hold_reg   <= wr_data;
                rxrb_pkg::REG_DOOR:   door_reg   <= wr_data;
                rxrb_pkg::REG_RESET:  reset_reg  <= wr_data;
                default: ;
            endcase
        end
    end

    // first match in register order wins
    always_comb
    begin
        if (line_byte == status_reg)
            evt = rxrb_pkg::EVT_STATUS;
        else if (line_byte == cycle_reg)
            evt = rxrb_pkg::EVT_CYCLE;
        else if (line_byte == hold_reg)
            evt = rxrb_pkg::EVT_HOLD;
        else if (line_byte == door_reg)
            evt = rxrb_pkg::EVT_DOOR;
        else if (line_byte == reset_reg)
            evt = rxrb_pkg::EVT_RESET;
        else
            evt = rxrb_pkg::EVT_NONE;
    end

endmodule

>>> src/rx_ring_buffer_with_realtime_filter.sv
// Top level: receive ring buffer with realtime command filter.
// Depends on rxrb_pkg, rxrb_cmd_if, rxrb_rsp_if, rxrb_filter and rxrb_ram.
//
//   channel   direction  transaction
//   cmd       sink       operation, line_byte
//   rsp       source     read_data, read_valid, fill_count, realtime_event, overflow
//   wr_*      sink       write enable, register index, register data
//
// One command per cycle sustained while rsp is not stalled; each result passes through the
// pending stage and then the output register, which also takes the store's registered read data.
// Reset clears both positions and loads the default command codes; the store needs no clearing.
// A stalled rsp holds the output register; one further command may then complete its
// memory access and wait in the pending stage before cmd.ready falls.
module rx_ring_buffer_with_realtime_filter #(
    parameter int BUFFER_DEPTH = rxrb_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rxrb_cmd_if.sink                    cmd,
    rxrb_rsp_if.source                  rsp,
    input  logic                        wr_en,
    input  logic [rxrb_pkg::IDX_W-1:0]  wr_index,
    input  logic [rxrb_pkg::BYTE_W-1:0] wr_data
);

    localparam int PTR_W = (BUFFER_DEPTH > 2) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(BUFFER_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);

    logic [PTR_W-1:0] wpos_reg, wpos_next, wpos_inc;
    logic [PTR_W-1:0] rpos_reg, rpos_next, rpos_inc;
    logic [rxrb_pkg::EVT_W-1:0] evt;
    logic accept, advance, is_empty, is_full;
    logic mem_we, mem_re;
    logic [rxrb_pkg::BYTE_W-1:0] rdata;
    logic [CNT_W-1:0] held;
    logic [CNT_W+rxrb_pkg::FILL_W-1:0] held_ext;

    rxrb_pkg::rxrb_status_t stat_now;
    rxrb_pkg::rxrb_status_t pend_reg;
    logic pend_valid_reg;
    rxrb_pkg::rxrb_status_t out_reg;
    logic [rxrb_pkg::BYTE_W-1:0] out_data_reg;
    logic out_valid_reg;

    rxrb_filter u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .line_byte (cmd.line_byte),
        .evt       (evt)
    );

    rxrb_ram #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wpos_reg),
        .wdata (cmd.line_byte),
        .re    (mem_re),
        .raddr (rpos_reg),
        .rdata (rdata)
    );

    assign advance   = pend_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !pend_valid_reg || advance;
    assign accept    = cmd.valid && cmd.ready;

    assign wpos_inc = (wpos_reg == LAST_POS) ? '0 : wpos_reg + PTR_W'(1);
    assign rpos_inc = (rpos_reg == LAST_POS) ? '0 : rpos_reg + PTR_W'(1);
    assign is_empty = (wpos_reg == rpos_reg);
    assign is_full  = (wpos_inc == rpos_reg);

    always_comb
    begin
        wpos_next    = wpos_reg;
        rpos_next    = rpos_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        stat_now.hit = 1'b0;
        stat_now.evt = rxrb_pkg::EVT_NONE;
        stat_now.ovf = 1'b0;
        if (accept)
        begin
            case (cmd.operation)
                rxrb_pkg::OP_RX:
                begin
                    stat_now.evt = evt;
                    if (evt == rxrb_pkg::EVT_NONE)
                    begin
                        if (is_full)
                        begin
                            stat_now.ovf = 1'b1;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            wpos_next = wpos_inc;
                        end
                    end
                end
                rxrb_pkg::OP_READ:
                begin
                    if (!is_empty)
                    begin
                        mem_re       = 1'b1;
                        stat_now.hit = 1'b1;
                        rpos_next    = rpos_inc;
                    end
                end
                rxrb_pkg::OP_FLUSH:
                begin
                    rpos_next = wpos_reg;
                end
                default: ;
            endcase
        end
        // fill after this transaction, truncated to the field width
        if (wpos_next >= rpos_next)
            held = CNT_W'(wpos_next) - CNT_W'(rpos_next);
        else
            held = DEPTH_CNT - CNT_W'(rpos_next) + CNT_W'(wpos_next);
        held_ext      = {{rxrb_pkg::FILL_W{1'b0}}, held};
        stat_now.fill = held_ext[rxrb_pkg::FILL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg       <= '0;
            rpos_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            wpos_reg <= wpos_next;
            rpos_reg <= rpos_next;
            if (accept)
                pend_valid_reg <= 1'b1;
            else if (advance)
                pend_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= stat_now;
        end
        if (advance)
        begin
            out_reg      <= pend_reg;
            out_data_reg <= pend_reg.hit ? rdata : rxrb_pkg::EMPTY_DATA;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.read_data      = out_data_reg;
    assign rsp.read_valid     = out_reg.hit;
    assign rsp.fill_count     = out_reg.fill;
    assign rsp.realtime_event = out_reg.evt;
    assign rsp.overflow       = out_reg.ovf;

endmodule

>>> tb/rxrb_ring_checker.sv
// Checker for the receive ring buffer: watches the command, response and register ports,
// predicts each response from its own ring state and command codes, and compares them.
// Depends on rxrb_pkg, rxrb_cmd_if and rxrb_rsp_if.
module rxrb_ring_checker #(
    parameter int DEPTH = rxrb_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rxrb_cmd_if                         cmd,
    rxrb_rsp_if                         rsp,
    input  logic                        wr_en,
    input  logic [rxrb_pkg::IDX_W-1:0]  wr_index,
    input  logic [rxrb_pkg::BYTE_W-1:0] wr_data,
    output int                          mismatches,
    output int                          pending,
    output int                          checked,
    output int                          pops,
    output int                          events,
    output int                          overflows
);

    typedef struct packed {
        logic [rxrb_pkg::BYTE_W-1:0] rd_data;
        logic                        popped;
        logic [rxrb_pkg::FILL_W-1:0] fill;
        logic [rxrb_pkg::EVT_W-1:0]  evt;
        logic                        ovf;
    } ring_result_t;

    logic [rxrb_pkg::BYTE_W-1:0] codes [rxrb_pkg::NUM_CODES];
    logic [rxrb_pkg::BYTE_W-1:0] ring [DEPTH];
    int                          head;
    int                          tail;
    ring_result_t                due_results [$];

    function automatic int next_pos(input int p);
        return (p + 1 == DEPTH) ? 0 : p + 1;
    endfunction

    function automatic ring_result_t ring_apply(input logic [1:0] op,
                                                input logic [rxrb_pkg::BYTE_W-1:0] b);
        ring_result_t r;
        int           nxt;
        r.rd_data = rxrb_pkg::EMPTY_DATA;
        r.popped  = 1'b0;
        r.evt     = rxrb_pkg::EVT_NONE;
        r.ovf     = 1'b0;
        case (op)
            rxrb_pkg::OP_RX:
            begin
                if (b == codes[rxrb_pkg::REG_STATUS])
                    r.evt = rxrb_pkg::EVT_STATUS;
                else if (b == codes[rxrb_pkg::REG_CYCLE])
                    r.evt = rxrb_pkg::EVT_CYCLE;
                else if (b == codes[rxrb_pkg::REG_HOLD])
                    r.evt = rxrb_pkg::EVT_HOLD;
                else if (b == codes[rxrb_pkg::REG_DOOR])
                    r.evt = rxrb_pkg::EVT_DOOR;
                else if (b == codes[rxrb_pkg::REG_RESET])
                    r.evt = rxrb_pkg::EVT_RESET;
                if (r.evt == rxrb_pkg::EVT_NONE)
                begin
                    nxt = next_pos(head);
                    if (nxt == tail)
                        r.ovf = 1'b1;
                    else
                    begin
                        ring[head] = b;
                        head = nxt;
                    end
                end
            end
            rxrb_pkg::OP_READ:
            begin
                if (head != tail)
                begin
                    r.rd_data = ring[tail];
                    r.popped  = 1'b1;
                    tail = next_pos(tail);
                end
            end
            rxrb_pkg::OP_FLUSH:
                tail = head;
            default:
                ;
        endcase
        r.fill = rxrb_pkg::FILL_W'((head - tail + DEPTH) % DEPTH);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (mismatches < 40)
            $display("%0t: mismatch on %s after %0d transactions: expected %0h, got %0h",
                     $time, what, checked, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ring_result_t want;
        ring_result_t got;
        if (!rst_n)
        begin
            codes[rxrb_pkg::REG_STATUS] = rxrb_pkg::CODE_STATUS_RST;
            codes[rxrb_pkg::REG_CYCLE]  = rxrb_pkg::CODE_CYCLE_RST;
            codes[rxrb_pkg::REG_HOLD]   = rxrb_pkg::CODE_HOLD_RST;
            codes[rxrb_pkg::REG_DOOR]   = rxrb_pkg::CODE_DOOR_RST;
            codes[rxrb_pkg::REG_RESET]  = rxrb_pkg::CODE_RESET_RST;
            head       = 0;
            tail       = 0;
            mismatches = 0;
            checked    = 0;
            pops       = 0;
            events     = 0;
            overflows  = 0;
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            if (wr_en && wr_index < rxrb_pkg::NUM_CODES)
                codes[wr_index] = wr_data;
            if (cmd.valid && cmd.ready)
                due_results.push_back(ring_apply(cmd.operation, cmd.line_byte));
            if (rsp.valid && rsp.ready)
            begin
                got.rd_data = rsp.read_data;
                got.popped  = rsp.read_valid;
                got.fill    = rsp.fill_count;
                got.evt     = rsp.realtime_event;
                got.ovf     = rsp.overflow;
                if (due_results.size() == 0)
                    report_mismatch("response with nothing outstanding", '0, 32'(got));
                else
                begin
                    want = due_results.pop_front();
                    if (got.rd_data !== want.rd_data)
                        report_mismatch("read_data", 32'(want.rd_data), 32'(got.rd_data));
                    if (got.popped !== want.popped)
                        report_mismatch("read_valid", 32'(want.popped), 32'(got.popped));
                    if (got.fill !== want.fill)
                        report_mismatch("fill_count", 32'(want.fill), 32'(got.fill));
                    if (got.evt !== want.evt)
                        report_mismatch("realtime_event", 32'(want.evt), 32'(got.evt));
                    if (got.ovf !== want.ovf)
                        report_mismatch("overflow", 32'(want.ovf), 32'(got.ovf));
                    checked++;
                    if (want.popped)
                        pops++;
                    if (want.evt != rxrb_pkg::EVT_NONE)
                        events++;
                    if (want.ovf)
                        overflows++;
                end
            end
            pending <= due_results.size();
        end
    end

endmodule

>>> tb/tb_rx_ring_buffer_with_realtime_filter.sv
// Testbench top for the receive ring buffer: drives commands, register writes and response
// back-pressure through several command-code settings, then gives the verdict.
// Depends on rxrb_pkg, rxrb_cmd_if, rxrb_rsp_if, rxrb_ring_checker and the block itself.
module tb_rx_ring_buffer_with_realtime_filter;

    localparam int                         DEPTH         = rxrb_pkg::BUFFER_DEPTH_DEF;
    localparam int                         CYCLE_LIMIT   = 200000;
    localparam int                         PHASE_ITEMS   = 260;
    localparam int                         CODE_SETTINGS = 6;
    localparam logic [1:0]                 OP_NONE       = 2'd3;
    localparam logic [rxrb_pkg::IDX_W-1:0] REG_SPARE     = 3'd7;

    logic                        clk;
    logic                        rst_n;
    logic                        wr_en;
    logic [rxrb_pkg::IDX_W-1:0]  wr_index;
    logic [rxrb_pkg::BYTE_W-1:0] wr_data;
    logic [rxrb_pkg::BYTE_W-1:0] codes_now [rxrb_pkg::NUM_CODES];
    bit                          cmd_steady;
    bit                          rsp_steady;
    int                          sent;
    int                          cycle_count;
    int                          mismatches;
    int                          pending;
    int                          checked;
    int                          pops;
    int                          events;
    int                          overflows;
    logic [rxrb_pkg::BYTE_W-1:0] dup_code;

    rxrb_cmd_if cmd_ch ();
    rxrb_rsp_if rsp_ch ();

    rx_ring_buffer_with_realtime_filter #(
        .BUFFER_DEPTH (DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_ch),
        .rsp      (rsp_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    rxrb_ring_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .rsp        (rsp_ch),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked),
        .pops       (pops),
        .events     (events),
        .overflows  (overflows)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic send(input logic [1:0] op, input logic [rxrb_pkg::BYTE_W-1:0] b);
        int gap;
        gap = cmd_steady ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.operation <= op;
        cmd_ch.line_byte <= b;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    function automatic logic [rxrb_pkg::BYTE_W-1:0] plain_byte();
        logic [rxrb_pkg::BYTE_W-1:0] b;
        bit                          hit;
        do
        begin
            b   = rxrb_pkg::BYTE_W'($urandom_range(0, 255));
            hit = 1'b0;
            foreach (codes_now[i])
                if (codes_now[i] == b)
                    hit = 1'b1;
        end
        while (hit);
        return b;
    endfunction

    function automatic logic [rxrb_pkg::BYTE_W-1:0] any_byte();
        return rxrb_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic rx_any();
        if ($urandom_range(0, 5) == 0)
            send(rxrb_pkg::OP_RX, codes_now[$urandom_range(0, rxrb_pkg::NUM_CODES - 1)]);
        else
            send(rxrb_pkg::OP_RX, any_byte());
    endtask

    task automatic write_reg(input logic [rxrb_pkg::IDX_W-1:0] idx,
                             input logic [rxrb_pkg::BYTE_W-1:0] v);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= v;
        if (idx < rxrb_pkg::NUM_CODES)
            codes_now[idx] = v;
        @(posedge clk);
    endtask

    task automatic apply_codes(input logic [rxrb_pkg::BYTE_W-1:0] status,
                               input logic [rxrb_pkg::BYTE_W-1:0] cycle,
                               input logic [rxrb_pkg::BYTE_W-1:0] hold,
                               input logic [rxrb_pkg::BYTE_W-1:0] door,
                               input logic [rxrb_pkg::BYTE_W-1:0] mreset);
        write_reg(REG_SPARE, any_byte());
        write_reg(rxrb_pkg::REG_STATUS, status);
        write_reg(rxrb_pkg::REG_CYCLE, cycle);
        write_reg(rxrb_pkg::REG_HOLD, hold);
        write_reg(rxrb_pkg::REG_DOOR, door);
        write_reg(rxrb_pkg::REG_RESET, mreset);
        wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic fill_to_overflow();
        repeat (DEPTH + 4) send(rxrb_pkg::OP_RX, plain_byte());
        repeat ($urandom_range(1, 24)) send(rxrb_pkg::OP_READ, any_byte());
        send(rxrb_pkg::OP_FLUSH, any_byte());
    endtask

    task automatic random_phase(input int n, input bit with_fill);
        int stop_at;
        int kind;
        int len;
        int pick;
        stop_at = sent + n;
        if (with_fill)
            fill_to_overflow();
        while (sent < stop_at)
        begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 24);
            case (kind)
                0, 1, 2, 3:
                    repeat (len) rx_any();
                4, 5:
                    repeat (len) send(rxrb_pkg::OP_READ, any_byte());
                6, 7:
                begin
                    repeat (len)
                    begin
                        pick = $urandom_range(0, 7);
                        if (pick < 3)
                            rx_any();
                        else if (pick < 6)
                            send(rxrb_pkg::OP_READ, any_byte());
                        else if (pick == 6)
                            send(rxrb_pkg::OP_FLUSH, any_byte());
                        else
                            send(OP_NONE, any_byte());
                    end
                end
                8:
                    send(rxrb_pkg::OP_FLUSH, any_byte());
                default:
                begin
                    cmd_steady = ($urandom_range(0, 2) == 0);
                    rsp_steady = ($urandom_range(0, 2) == 0);
                end
            endcase
        end
    endtask

    // response back-pressure
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = rsp_steady ? 0 : $urandom_range(0, 3);
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("rx_ring_buffer_with_realtime_filter regression: fail");
        $finish;
    end

    initial
    begin
        rst_n            <= 1'b0;
        wr_en            <= 1'b0;
        wr_index         <= rxrb_pkg::REG_STATUS;
        wr_data          <= '0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.operation <= rxrb_pkg::OP_RX;
        cmd_ch.line_byte <= '0;
        cmd_steady = 1'b0;
        rsp_steady = 1'b0;
        sent       = 0;
        codes_now[rxrb_pkg::REG_STATUS] = rxrb_pkg::CODE_STATUS_RST;
        codes_now[rxrb_pkg::REG_CYCLE]  = rxrb_pkg::CODE_CYCLE_RST;
        codes_now[rxrb_pkg::REG_HOLD]   = rxrb_pkg::CODE_HOLD_RST;
        codes_now[rxrb_pkg::REG_DOOR]   = rxrb_pkg::CODE_DOOR_RST;
        codes_now[rxrb_pkg::REG_RESET]  = rxrb_pkg::CODE_RESET_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // read when empty, every event at its reset code, byte extremes, flush
        send(rxrb_pkg::OP_READ, 8'h00);
        send(rxrb_pkg::OP_RX, rxrb_pkg::CODE_STATUS_RST);
        send(rxrb_pkg::OP_RX, rxrb_pkg::CODE_CYCLE_RST);
        send(rxrb_pkg::OP_RX, rxrb_pkg::CODE_HOLD_RST);
        send(rxrb_pkg::OP_RX, rxrb_pkg::CODE_DOOR_RST);
        send(rxrb_pkg::OP_RX, rxrb_pkg::CODE_RESET_RST);
        send(rxrb_pkg::OP_RX, 8'h00);
        send(rxrb_pkg::OP_RX, 8'hFF);
        send(rxrb_pkg::OP_RX, 8'h55);
        send(rxrb_pkg::OP_RX, 8'hAA);
        send(OP_NONE, 8'hFF);
        send(rxrb_pkg::OP_READ, 8'hFF);
        send(rxrb_pkg::OP_READ, 8'h00);
        send(rxrb_pkg::OP_READ, 8'h55);
        send(rxrb_pkg::OP_FLUSH, 8'hAA);
        send(rxrb_pkg::OP_READ, 8'h00);
        send(rxrb_pkg::OP_RX, 8'h01);
        send(rxrb_pkg::OP_RX, 8'h80);
        send(rxrb_pkg::OP_READ, 8'h00);
        send(rxrb_pkg::OP_READ, 8'h00);
        send(rxrb_pkg::OP_READ, 8'h00);
        send(OP_NONE, 8'h00);

        random_phase(PHASE_ITEMS, 1'b0);
        wait_idle();
        apply_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        random_phase(PHASE_ITEMS, 1'b1);
        wait_idle();
        apply_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        random_phase(PHASE_ITEMS, 1'b0);
        wait_idle();
        apply_codes(8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01);
        random_phase(PHASE_ITEMS, 1'b1);
        wait_idle();
        dup_code = any_byte();
        apply_codes(any_byte(), dup_code, any_byte(), any_byte(), dup_code);
        random_phase(PHASE_ITEMS, 1'b0);
        wait_idle();
        apply_codes(rxrb_pkg::CODE_STATUS_RST, rxrb_pkg::CODE_CYCLE_RST,
                    rxrb_pkg::CODE_HOLD_RST, rxrb_pkg::CODE_DOOR_RST,
                    rxrb_pkg::CODE_RESET_RST);
        random_phase(PHASE_ITEMS, 1'b1);
        wait_idle();

        $display("%0d transactions over %0d command-code settings: %0d bytes popped,",
                 checked, CODE_SETTINGS, pops);
        $display("%0d realtime events, %0d overflow drops, %0d mismatches",
                 events, overflows, mismatches);
        if (mismatches == 0)
            $display("rx_ring_buffer_with_realtime_filter regression: pass");
        else
            $display("rx_ring_buffer_with_realtime_filter regression: fail");
        $finish;
    end

endmodule

>>> sim.f
src/rxrb_pkg.sv
src/rxrb_cmd_if.sv
src/rxrb_rsp_if.sv
src/rxrb_ram.sv
src/rxrb_filter.sv
src/rx_ring_buffer_with_realtime_filter.sv
tb/rxrb_ring_checker.sv
tb/tb_rx_ring_buffer_with_realtime_filter.sv
